[hdl/ctfm_pkg.sv]
package ctfm_pkg;

  localparam int unsigned YearW = 7;
  localparam int unsigned MonW  = 4;
  localparam int unsigned DayW  = 5;
  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned CntW  = 23;

  // day count up to 2127 stays below 2^16
  localparam int unsigned DaysW = 16;
  // 2^16 days of 1440 minutes plus an hour and minute term fit in 27 bits
  localparam int unsigned TotW  = 27;

  // floor(x / 5) = (x * ceil(2^30 / 5)) >> 30 for every x below 2^30
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW     = 28;
  localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << RecipShift) + 64'd4) / 64'd5);

  localparam logic [YearW-1:0] FirstYear    = YearW'(25);   // 2025
  localparam logic [YearW-1:0] CenturyYear  = YearW'(100);  // 2100, not a leap year
  localparam logic [MonW-1:0]  MonthsInYear = MonW'(12);
  localparam logic [MonW-1:0]  February     = MonW'(2);
  localparam logic [CntW-1:0]  CountMax     = {CntW{1'b1}};

  localparam logic [DaysW-1:0] DaysCommon = DaysW'(365);
  localparam logic [DaysW-1:0] DaysLeap   = DaysW'(366);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_YEAR  = 7'b0000010,
    S_MONTH = 7'b0000100,
    S_DAY   = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } ctfm_state_e;

  // years since 2000 within 2000 to 2127
  function automatic logic is_leap(input logic [YearW-1:0] ys);
    is_leap = (ys[1:0] == 2'b00) && (ys != CenturyYear);
  endfunction

  function automatic logic [DaysW-1:0] month_len(input logic [MonW-1:0] idx);
    logic [DaysW-1:0] len;
    case (idx)
      4'd1:    len = DaysW'(28);
      4'd3:    len = DaysW'(30);
      4'd5:    len = DaysW'(30);
      4'd8:    len = DaysW'(30);
      4'd10:   len = DaysW'(30);
      default: len = DaysW'(31);
    endcase
    return len;
  endfunction

endpackage

[hdl/ctfm_if.sv]
interface ctfm_in_if
  import ctfm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [YearW-1:0] year_since_2000;
  logic [MonW-1:0]  month_number;
  logic [DayW-1:0]  day_of_month;
  logic [HourW-1:0] hour_of_day;
  logic [MinW-1:0]  minute_of_hour;

  modport source (
    output valid, year_since_2000, month_number, day_of_month, hour_of_day, minute_of_hour,
    input  ready
  );
  modport sink (
    input  valid, year_since_2000, month_number, day_of_month, hour_of_day, minute_of_hour,
    output ready
  );
endinterface

interface ctfm_out_if
  import ctfm_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CntW-1:0] five_minute_count;
  logic            before_reference;

  modport source (
    output valid, five_minute_count, before_reference,
    input  ready
  );
  modport sink (
    input  valid, five_minute_count, before_reference,
    output ready
  );
endinterface

[hdl/ctfm_div5.sv]
module ctfm_div5
  import ctfm_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [TotW-1:0] total_i,
  output logic [CntW-1:0] count_o
);

  localparam int unsigned ProdW = TotW + RecipW;
  localparam int unsigned QuotW = ProdW - RecipShift;

  logic [ProdW-1:0] prod_q;
  logic [QuotW-1:0] quot;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(total_i) * ProdW'(Recip);
    end
  end

  assign quot = prod_q[ProdW-1:RecipShift];

  // saturate to the output width
  assign count_o = (quot > QuotW'(CountMax)) ? CountMax : quot[CntW-1:0];

endmodule

[hdl/calendar_to_five_minute_timestamp_core.sv]
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | year_since_2000, month_number, day_of_month,
//         |     |               | hour_of_day, minute_of_hour
// out_o   | out | valid / ready | five_minute_count, before_reference
//
// one item at a time; a shared 16-bit day adder walks the years, then the months,
// then adds the day; days in minutes plus hour and minute are divided by five
// the result is loaded once out_o is free, and the next item is taken in the cycle
// after; a year before 2025 skips the walks and goes straight to the last step
// in_i.ready is high only while the sequencer is idle
// rst_ni clears the sequencer and the output valid; a result held by out_o.ready
// low stalls the sequencer in its last step
module calendar_to_five_minute_timestamp_core
  import ctfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ctfm_in_if.sink    in_i,
  ctfm_out_if.source out_o
);

  ctfm_state_e state_q, state_d;

  logic [YearW-1:0] yr_q;
  logic [MonW-1:0]  mon_q;
  logic [DayW-1:0]  day_q;
  logic [HourW-1:0] hr_q;
  logic [MinW-1:0]  min_q;
  logic [YearW-1:0] yc_q, yc_d;
  logic [MonW-1:0]  mi_q, mi_d;
  logic [MonW-1:0]  nmon_q, nmon_d;
  logic [DaysW-1:0] acc_q, acc_d;
  logic [TotW-1:0]  tot_q, tot_d;
  logic             flag_q, flag_d;
  logic             out_valid_q, out_valid_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic             out_flag_q, out_flag_d;

  logic             accept;
  logic             load_out;
  logic             div_en;
  logic [DaysW-1:0] add_b;
  logic             add_cin;
  logic [DaysW-1:0] add_sum;
  logic [TotW-1:0]  hm_term;
  logic [CntW-1:0]  div_cnt;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign div_en     = (state_q == S_DIV);

  // shared day adder
  always_comb begin
    add_b   = '0;
    add_cin = 1'b0;
    case (state_q)
      S_YEAR:  add_b = is_leap(yc_q) ? DaysLeap : DaysCommon;
      S_MONTH: add_b = month_len(mi_q);
      S_DAY: begin
        add_b   = (day_q == '0) ? '0 : DaysW'(day_q - DayW'(1));
        add_cin = (mon_q > February) && is_leap(yr_q);
      end
      default: add_b = '0;
    endcase
  end

  assign add_sum = acc_q + add_b + DaysW'(add_cin);

  // hour * 60 + minute, hour * 60 as 64h - 4h
  assign hm_term = (TotW'(hr_q) << 6) - (TotW'(hr_q) << 2) + TotW'(min_q);

  ctfm_div5 u_div5 (
    .clk_i   (clk_i),
    .en_i    (div_en),
    .total_i (tot_q),
    .count_o (div_cnt)
  );

  always_comb begin
    state_d     = state_q;
    yc_d        = yc_q;
    mi_d        = mi_q;
    nmon_d      = nmon_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    out_flag_d  = out_flag_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          yc_d  = FirstYear;
          mi_d  = '0;
          acc_d = '0;
          if (in_i.month_number == '0) begin
            nmon_d = '0;
          end else if (in_i.month_number > MonthsInYear) begin
            nmon_d = MonthsInYear;
          end else begin
            nmon_d = in_i.month_number - MonW'(1);
          end
          flag_d  = (in_i.year_since_2000 < FirstYear);
          state_d = (in_i.year_since_2000 < FirstYear) ? S_DONE : S_YEAR;
        end
      end
      S_YEAR: begin
        if (yc_q == yr_q) begin
          state_d = S_MONTH;
        end else begin
          acc_d = add_sum;
          yc_d  = yc_q + YearW'(1);
        end
      end
      S_MONTH: begin
        if (mi_q == nmon_q) begin
          state_d = S_DAY;
        end else begin
          acc_d = add_sum;
          mi_d  = mi_q + MonW'(1);
        end
      end
      S_DAY: begin
        acc_d   = add_sum;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        // days * 1440 as 1024 + 256 + 128 + 32
        tot_d = (TotW'(acc_q) << 10) + (TotW'(acc_q) << 8) + (TotW'(acc_q) << 7)
              + (TotW'(acc_q) << 5) + hm_term;
        state_d = S_DIV;
      end
      S_DIV: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_cnt_d   = flag_q ? '0 : div_cnt;
          out_flag_d  = flag_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      yc_q        <= '0;
      mi_q        <= '0;
      nmon_q      <= '0;
      flag_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      yc_q        <= yc_d;
      mi_q        <= mi_d;
      nmon_q      <= nmon_d;
      flag_q      <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      yr_q  <= in_i.year_since_2000;
      mon_q <= in_i.month_number;
      day_q <= in_i.day_of_month;
      hr_q  <= in_i.hour_of_day;
      min_q <= in_i.minute_of_hour;
    end
    acc_q      <= acc_d;
    tot_q      <= tot_d;
    out_cnt_q  <= out_cnt_d;
    out_flag_q <= out_flag_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.five_minute_count = out_cnt_q;
  assign out_o.before_reference  = out_flag_q;

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.before_reference |-> out_o.five_minute_count == '0)
    else $error("flagged item carries a nonzero count");

  a_early_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.year_since_2000 < FirstYear) |=> (state_q == S_DONE) && flag_q)
    else $error("year before 2025 did not go straight to the result");

  a_year_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR) |-> (yc_q <= yr_q) && !flag_q)
    else $error("year walk passed the target year");

  a_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MONTH) |-> (mi_q <= nmon_q) && (nmon_q <= MonthsInYear))
    else $error("month walk passed the month count");

endmodule

[dv/tb_calendar_to_five_minute_timestamp_core.sv]
module tb_calendar_to_five_minute_timestamp_core
  import ctfm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BaseYear    = 2000;
  localparam int unsigned EpochYear   = 2025;
  localparam int unsigned MinPerDay   = 1440;
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned UnitMinutes = 5;
  localparam int unsigned DaysCommonN = 365;
  localparam int unsigned DaysLeapN   = 366;
  localparam int unsigned IdlePercent = 22;
  localparam int unsigned RandomDates = 800;
  localparam int unsigned WatchdogMax = 4000;
  localparam int unsigned TailCycles  = 200;
  localparam int unsigned PrintCap    = 100;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
  } cal_date_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            flagged;
  } stamp_t;

  typedef struct packed {
    cal_date_t date;
    stamp_t    stamp;
  } dated_stamp_t;

  class stamp_board;
    dated_stamp_t pending_stamps [$];
    int unsigned  mismatches = 0;

    static function bit leap_year(int unsigned y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400) == 0;
    endfunction

    static function stamp_t five_minute_stamp(cal_date_t d);
      int unsigned yr, days, months, total, units;
      stamp_t s;
      yr = BaseYear + d.year;
      if (yr < EpochYear) begin
        s.count   = '0;
        s.flagged = 1'b1;
        return s;
      end
      days = 0;
      for (int unsigned y = EpochYear; y < yr; y++) begin
        days += leap_year(y) ? DaysLeapN : DaysCommonN;
      end
      months = (d.month == 0) ? 0 : d.month - 1;
      if (months > MonthsInYear) months = MonthsInYear;
      for (int unsigned m = 0; m < months; m++) begin
        days += MonthDays[m];
      end
      // leap day once february is behind us
      if (d.month > February && leap_year(yr)) days += 1;
      if (d.day > 0) days += d.day - 1;
      total = days * MinPerDay + d.hour * MinPerHour + d.minute;
      units = total / UnitMinutes;
      if (units > CountMax) units = CountMax;
      s.count   = CntW'(units);
      s.flagged = 1'b0;
      return s;
    endfunction

    task report(string msg);
      if (mismatches < PrintCap) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_date(cal_date_t d);
      dated_stamp_t e;
      e.date  = d;
      e.stamp = five_minute_stamp(d);
      pending_stamps.push_back(e);
    endfunction

    task check_stamp(stamp_t got);
      dated_stamp_t want;
      if (pending_stamps.size() == 0) begin
        report($sformatf("result with nothing pending: count %0d flag %0b",
                         got.count, got.flagged));
        return;
      end
      want = pending_stamps.pop_front();
      if (got.count !== want.stamp.count)
        report($sformatf("y%0d m%0d d%0d %0d:%0d count got %0d want %0d",
                         want.date.year, want.date.month, want.date.day, want.date.hour,
                         want.date.minute, got.count, want.stamp.count));
      if (got.flagged !== want.stamp.flagged)
        report($sformatf("y%0d m%0d d%0d %0d:%0d flag got %0b want %0b",
                         want.date.year, want.date.month, want.date.day, want.date.hour,
                         want.date.minute, got.flagged, want.stamp.flagged));
    endtask

    function int unsigned pending();
      return pending_stamps.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int unsigned stall_cycles;
  bit   progress;
  stamp_board board;

  ctfm_in_if  date_if ();
  ctfm_out_if stamp_if ();

  calendar_to_five_minute_timestamp_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (date_if),
    .out_o  (stamp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin
    stamp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      stamp_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  // result check first, then note the accepted date, then the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (stamp_if.valid && stamp_if.ready) begin
        board.check_stamp({stamp_if.five_minute_count, stamp_if.before_reference});
        progress = 1'b1;
      end
      if (date_if.valid && date_if.ready) begin
        board.note_date({date_if.year_since_2000, date_if.month_number, date_if.day_of_month,
                         date_if.hour_of_day, date_if.minute_of_hour});
        progress = 1'b1;
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= WatchdogMax) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task send_date(cal_date_t d);
    if (!steady) begin
      while ($urandom_range(99) < IdlePercent) begin
        date_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    date_if.valid           <= 1'b1;
    date_if.year_since_2000 <= d.year;
    date_if.month_number    <= d.month;
    date_if.day_of_month    <= d.day;
    date_if.hour_of_day     <= d.hour;
    date_if.minute_of_hour  <= d.minute;
    do @(posedge clk_i); while (!date_if.ready);
  endtask

  task send_fields(int unsigned y, int unsigned mo, int unsigned dd, int unsigned h,
                   int unsigned mi);
    cal_date_t d;
    d = {YearW'(y), MonW'(mo), DayW'(dd), HourW'(h), MinW'(mi)};
    send_date(d);
  endtask

  // hold the sender until every pending result is back
  task drain();
    date_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic cal_date_t random_date();
    cal_date_t d;
    int unsigned sel, mlen;
    sel = $urandom_range(99);
    if (sel < 70)      d.year = YearW'($urandom_range(99, 25));
    else if (sel < 80) d.year = YearW'($urandom_range(24, 0));
    else               d.year = YearW'($urandom_range(127, 0));
    d.month = MonW'(($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(15, 0));
    mlen = 31;
    if (d.month >= 1 && d.month <= MonthsInYear) begin
      mlen = MonthDays[d.month - 1];
      if (d.month == February && stamp_board::leap_year(BaseYear + d.year)) mlen++;
    end
    d.day    = DayW'(($urandom_range(99) < 90) ? $urandom_range(mlen, 1)
                                                : $urandom_range(31, 0));
    d.hour   = HourW'(($urandom_range(99) < 90) ? $urandom_range(23, 0)
                                                 : $urandom_range(31, 0));
    d.minute = MinW'(($urandom_range(99) < 90) ? $urandom_range(59, 0)
                                                : $urandom_range(63, 0));
    return d;
  endfunction

  initial begin
    board  = new();
    steady = 1'b0;
    stall_cycles = 0;
    rst_ni                  <= 1'b0;
    date_if.valid           <= 1'b0;
    date_if.year_since_2000 <= '0;
    date_if.month_number    <= '0;
    date_if.day_of_month    <= '0;
    date_if.hour_of_day     <= '0;
    date_if.minute_of_hour  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before the epoch, including all other fields at their widest
    send_fields(0, 15, 31, 31, 63);
    send_fields(24, 12, 31, 23, 59);
    // epoch start and rounding at the unit boundary
    send_fields(25, 1, 1, 0, 0);
    send_fields(25, 1, 1, 0, 4);
    send_fields(25, 1, 1, 0, 5);
    send_fields(25, 12, 31, 23, 59);
    // leap year around the leap day
    send_fields(28, 2, 29, 23, 59);
    send_fields(28, 3, 1, 0, 0);
    send_fields(27, 3, 1, 0, 0);
    // month zero, months past december, day zero
    send_fields(28, 0, 10, 5, 30);
    send_fields(28, 13, 1, 0, 0);
    send_fields(27, 15, 1, 0, 0);
    send_fields(26, 6, 0, 12, 0);
    // hour and minute beyond their ranges, and the last minute of 2099
    send_fields(25, 1, 1, 31, 63);
    send_fields(99, 12, 31, 23, 59);
    // century year is common, the next multiple of four is leap
    send_fields(100, 3, 1, 0, 0);
    send_fields(104, 3, 1, 0, 0);
    // saturation near the top of the year range
    send_fields(126, 1, 1, 0, 0);
    send_fields(127, 12, 31, 23, 59);
    send_fields(127, 15, 31, 31, 63);
    drain();

    for (int n = 0; n < RandomDates; n++) begin
      steady = (n >= 300 && n < 450);
      send_date(random_date());
      if (n == 600) drain();
    end
    steady = 1'b0;
    drain();
    repeat (TailCycles) @(posedge clk_i);

    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ctfm_pkg.sv
hdl/ctfm_if.sv
hdl/ctfm_div5.sv
hdl/calendar_to_five_minute_timestamp_core.sv
dv/tb_calendar_to_five_minute_timestamp_core.sv
